FILE: design/sba_pkg.sv
// sba_pkg: shared types and constants for the sync marker bit aligner
// depends on nothing; used by sba_core, sba_fifo and sync_marker_bit_aligner
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

	localparam int unsigned SYNC_BITS_DEF = 32;
	localparam logic [31:0] SYNC_WORD_RESET = 32'h1ACF_FC1D;

	// result queue depth, room for two beats per accepted byte
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NO_SYNC = 1'b1;

	typedef struct packed {
		logic last_out;
		logic status;
		logic [2:0] bit_offset;
		logic [7:0] aligned_byte;
	} result_t;

	// results produced by one byte, count is 0..2
	typedef struct packed {
		logic [1:0] count;
		result_t r0;
		result_t r1;
	} res_pair_t;

endpackage

`default_nettype wire

FILE: design/sba_core.sv
// sba_core: marker search over eight bit positions per byte and realignment
// depends on sba_pkg; holds the search window, lock, offset and held byte
`timescale 1ns / 1ps
`default_nettype none

module sba_core #(
	parameter int unsigned SYNC_BITS = sba_pkg::SYNC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire logic [7:0] data_byte,
	input wire logic end_of_stream,
	input wire logic [31:0] sync_word,
	output sba_pkg::res_pair_t res
);

	localparam int unsigned EXT_W = SYNC_BITS + 8;

	logic locked_q;
	logic [SYNC_BITS-1:0] window_q;
	logic [2:0] shift_q;
	logic [7:0] held_q;

	logic [SYNC_BITS-1:0] target;
	logic [EXT_W-1:0] ext;
	logic [7:0] match;
	logic hit;
	logic [2:0] hit_idx;
	logic [2:0] hit_shift;
	logic [15:0] pair_shifted;
	logic [7:0] aligned_val;
	logic [7:0] flush_val;

	assign target = SYNC_BITS'(sync_word);
	assign ext = {window_q, data_byte};

	// window after bit i of the byte has been shifted in
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			match[i] = (ext[SYNC_BITS + 6 - i -: SYNC_BITS] == target);
		end
	end

	// first matching bit wins
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				hit_idx = 3'(i);
			end
		end
	end

	assign hit_shift = hit_idx + 3'd1;
	assign pair_shifted = {held_q, data_byte} << shift_q;
	// offset zero passes the current byte straight through
	assign aligned_val = (shift_q == 3'd0) ? data_byte : pair_shifted[15:8];
	assign flush_val = data_byte << shift_q;

	always_comb begin
		res = '0;
		if (fire) begin
			if (locked_q) begin
				res.r0.aligned_byte = aligned_val;
				res.r0.bit_offset = shift_q;
				res.r0.status = sba_pkg::STATUS_OK;
				res.r0.last_out = end_of_stream && (shift_q == 3'd0);
				res.r1.aligned_byte = flush_val;
				res.r1.bit_offset = shift_q;
				res.r1.status = sba_pkg::STATUS_OK;
				res.r1.last_out = 1'b1;
				res.count = (end_of_stream && (shift_q != 3'd0)) ? 2'd2 : 2'd1;
			end else if (hit) begin
				// marker ends in this byte, flush its tail only at end of stream
				res.r0.aligned_byte = data_byte << hit_shift;
				res.r0.bit_offset = hit_shift;
				res.r0.status = sba_pkg::STATUS_OK;
				res.r0.last_out = 1'b1;
				res.count = (end_of_stream && (hit_shift != 3'd0)) ? 2'd1 : 2'd0;
			end else if (end_of_stream) begin
				res.r0.status = sba_pkg::STATUS_NO_SYNC;
				res.r0.last_out = 1'b1;
				res.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			window_q <= '0;
			shift_q <= '0;
			held_q <= '0;
		end else if (fire) begin
			if (end_of_stream) begin
				locked_q <= 1'b0;
				window_q <= '0;
				shift_q <= '0;
				held_q <= '0;
			end else if (locked_q) begin
				held_q <= data_byte;
			end else if (hit) begin
				locked_q <= 1'b1;
				shift_q <= hit_shift;
				held_q <= data_byte;
			end else begin
				window_q <= ext[SYNC_BITS-1:0];
			end
		end
	end

	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd2) |-> (end_of_stream && locked_q && (shift_q != 3'd0)))
		else $error("two results without end of stream flush");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		((res.count != 2'd0) && (res.r0.status == sba_pkg::STATUS_NO_SYNC))
		|-> (res.r0.last_out && (res.r0.aligned_byte == 8'd0) && !locked_q))
		else $error("no-sync result malformed");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_stream) |=> (!locked_q && (window_q == '0)))
		else $error("state not cleared after end of stream");

endmodule

`default_nettype wire

FILE: design/sba_fifo.sv
// sba_fifo: small result queue, up to two beats written and one read per cycle
// depends on sba_pkg for the result type and depth
`timescale 1ns / 1ps
`default_nettype none

module sba_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire sba_pkg::res_pair_t wr,
	output logic room,
	output logic rd_valid,
	input wire logic rd_ready,
	output sba_pkg::result_t rd_data
);

	localparam int unsigned DEPTH = sba_pkg::FIFO_DEPTH;
	localparam int unsigned PW = sba_pkg::PTR_W;
	localparam int unsigned CW = sba_pkg::CNT_W;

	sba_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic pop;
	logic [PW-1:0] wr_ptr_nx1;

	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign pop = rd_valid && rd_ready;
	assign room = (count_q <= CW'(DEPTH - 2));
	assign wr_ptr_nx1 = wr_ptr_q + PW'(1);

	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (wr.count == 2'd2) begin
			mem_q[wr_ptr_nx1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(wr.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(wr.count) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.count != 2'd0) |-> room)
		else $error("push without room");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

FILE: design/sync_marker_bit_aligner.sv
// input register holds an accepted byte until the four-entry result queue has room
// throughput: one byte per cycle while the queue has room; the end-of-stream byte with
// a nonzero offset gives two beats, set by the one-beat-per-cycle queue read port
// reset: arst_n clears search state, lock and queue; sync_word returns to 0x1ACFFC1D
// top level: input register, sba_core search/realign, sba_fifo result queue
`timescale 1ns / 1ps
`default_nettype none

module sync_marker_bit_aligner #(
	parameter int unsigned SYNC_BITS = sba_pkg::SYNC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sync_word_we,
	input wire logic [31:0] sync_word,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // data_byte
	input wire logic s_tlast, // end_of_stream
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata, // aligned_byte, bit_offset, zero fill
	output logic m_tuser, // status
	output logic m_tlast // last_out
);

	logic [31:0] sync_word_q;
	logic v_s1;
	logic [7:0] byte_s1;
	logic eos_s1;
	logic fire;
	logic room;
	sba_pkg::res_pair_t res;
	sba_pkg::result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= sba_pkg::SYNC_WORD_RESET;
		end else if (sync_word_we) begin
			sync_word_q <= sync_word;
		end
	end

	assign fire = v_s1 && room;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1 <= s_tlast;
		end
	end

	sba_core #(
		.SYNC_BITS(SYNC_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.data_byte(byte_s1),
		.end_of_stream(eos_s1),
		.sync_word(sync_word_q),
		.res(res)
	);

	sba_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res),
		.room(room),
		.rd_valid(m_tvalid),
		.rd_ready(m_tready),
		.rd_data(out_res)
	);

	assign m_tdata = {5'd0, out_res.bit_offset, out_res.aligned_byte};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last_out;

endmodule

`default_nettype wire

FILE: tb/sv/sba_align_checker.sv
// sba_align_checker: watches both stream ports and the sync word port of the aligner,
// predicts the realigned beats of every accepted byte and compares them in order
// depends on sba_pkg for result_t, the status codes and the sync word reset value
`timescale 1ns / 1ps

module sba_align_checker (
	input logic clk,
	input logic arst_n,
	input logic sync_word_we,
	input logic [31:0] sync_word,
	input logic s_tvalid,
	input logic s_tready,
	input logic [7:0] s_tdata, // data_byte
	input logic s_tlast, // end_of_stream
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata, // aligned_byte, bit_offset, zero fill
	input logic m_tuser, // status
	input logic m_tlast, // last_out
	output int fail_count,
	output int outstanding
);

	logic [31:0] marker_word = sba_pkg::SYNC_WORD_RESET;
	logic [31:0] hunt_window = '0;
	logic in_lock = 1'b0;
	logic [2:0] lock_shift = '0;
	logic [7:0] prev_byte = '0;
	sba_pkg::result_t due_beats[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	task automatic queue_beat(input logic [7:0] data, input logic [2:0] offset,
		input logic status, input logic last);
		sba_pkg::result_t r;
		r.aligned_byte = data;
		r.bit_offset = offset;
		r.status = status;
		r.last_out = last;
		due_beats.push_back(r);
	endtask

	task automatic clear_search();
		in_lock = 1'b0;
		hunt_window = '0;
		lock_shift = '0;
		prev_byte = '0;
	endtask

	// one accepted byte in, zero to two realigned beats queued
	task automatic realign_byte(input logic [7:0] b, input logic eos);
		int i;
		logic [2:0] s;
		logic [7:0] v;
		if (!in_lock) begin
			for (i = 0; i < 8 && !in_lock; i++) begin
				hunt_window = {hunt_window[30:0], b[7 - i]};
				if (hunt_window == marker_word) begin
					in_lock = 1'b1;
					lock_shift = 3'(i + 1);
					prev_byte = b;
				end
			end
			if (in_lock) begin
				if (eos) begin
					// marker ended inside the last byte, flush its tail bits
					if (lock_shift != 0)
						queue_beat(prev_byte << lock_shift, lock_shift,
							sba_pkg::STATUS_OK, 1'b1);
					clear_search();
				end
			end else if (eos) begin
				queue_beat(8'h00, 3'd0, sba_pkg::STATUS_NO_SYNC, 1'b1);
				clear_search();
			end
		end else begin
			s = lock_shift;
			if (s == 0)
				v = b;
			else
				v = (prev_byte << s) | (b >> (8 - s));
			queue_beat(v, s, sba_pkg::STATUS_OK, eos && s == 0);
			prev_byte = b;
			if (eos) begin
				if (s != 0)
					queue_beat(b << s, s, sba_pkg::STATUS_OK, 1'b1);
				clear_search();
			end
		end
	endtask

	task automatic note_diff(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sba_pkg::result_t want;
		if (!arst_n) begin
			marker_word = sba_pkg::SYNC_WORD_RESET;
			clear_search();
			due_beats.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_beats.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected beat, expected none actual %h user %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = due_beats.pop_front();
					note_diff("aligned_byte", want.aligned_byte, m_tdata[7:0]);
					note_diff("bit_offset", want.bit_offset, m_tdata[10:8]);
					note_diff("status", want.status, m_tuser);
					note_diff("last_out", want.last_out, m_tlast);
					note_diff("zero fill", 16'h0, m_tdata[15:11]);
				end
			end
			if (sync_word_we)
				marker_word = sync_word;
			if (s_tvalid && s_tready)
				realign_byte(s_tdata, s_tlast);
		end
		outstanding = due_beats.size();
	end

endmodule

FILE: tb/sv/tb_sync_marker_bit_aligner.sv
// tb_sync_marker_bit_aligner: drives byte streams with the sync marker at every bit
// offset, noise and broken markers, under several sync words and random stalls
// depends on sba_pkg, sync_marker_bit_aligner and sba_align_checker
`timescale 1ns / 1ps

module tb_sync_marker_bit_aligner;

	localparam int RANDOM_BYTES = 1850;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic sync_word_we;
	logic [31:0] sync_word;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	int fail_count;
	int outstanding;
	int bytes_sent = 0;
	int beats_taken = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	bit long_hold_done = 1'b0;
	logic [31:0] cur_sync = sba_pkg::SYNC_WORD_RESET;

	sync_marker_bit_aligner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sync_word_we(sync_word_we),
		.sync_word(sync_word),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	sba_align_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sync_word_we(sync_word_we),
		.sync_word(sync_word),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stop when neither port nor the register moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || sync_word_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random gap before each beat, one long hold-off to back up the input
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!long_hold_done && beats_taken >= 150) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			beats_taken++;
			@(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= b;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// random prefix bits, the first mbits of the marker, random tail bits, random pad
	task automatic send_stream(input int pbits, input int mbits, input int tbits);
		bit stream_bits[$];
		int k;
		int j;
		logic [7:0] b;
		no_gaps = ($urandom_range(0, 4) == 0);
		repeat (pbits) stream_bits.push_back($urandom_range(0, 1));
		for (k = 31; k > 31 - mbits; k--)
			stream_bits.push_back(cur_sync[k]);
		repeat (tbits) stream_bits.push_back($urandom_range(0, 1));
		while (stream_bits.size() == 0 || stream_bits.size() % 8 != 0)
			stream_bits.push_back($urandom_range(0, 1));
		for (k = 0; k < stream_bits.size(); k += 8) begin
			for (j = 0; j < 8; j++)
				b[7 - j] = stream_bits[k + j];
			send_byte(b, k + 8 >= stream_bits.size());
		end
	endtask

	// drop valid, wait for every expected beat, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_sync(input logic [31:0] v);
		settle();
		cur_sync = v;
		sync_word <= v;
		sync_word_we <= 1'b1;
		@(negedge clk);
		sync_word_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_streams(input int goal);
		int pick;
		while (bytes_sent < goal) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				send_stream($urandom_range(0, 40), 32, $urandom_range(0, 96));
			else if (pick < 17)
				send_stream($urandom_range(0, 40), $urandom_range(8, 31), $urandom_range(0, 24));
			else
				send_stream(0, 0, 8 * $urandom_range(1, 8));
		end
	endtask

	initial begin
		logic [31:0] sync_list[4];
		int p;
		sync_list[0] = 32'h0000_0000;
		sync_list[1] = 32'hFFFF_FFFF;
		sync_list[2] = $urandom();
		sync_list[3] = sba_pkg::SYNC_WORD_RESET;
		arst_n = 1'b0;
		sync_word_we = 1'b0;
		sync_word = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset sync word
		send_byte(8'h00, 1'b1); // stream ends with no marker
		send_byte(8'hFF, 1'b1);
		send_stream(0, 32, 16); // byte-aligned marker, payload passes through
		send_stream(4, 32, 0); // marker ends mid final byte, flush only
		send_stream(0, 32, 0); // marker fills the final byte, no beat at all
		send_stream(7, 32, 9); // offset seven, bits after the match realigned

		for (p = 0; p < 4; p++) begin
			write_sync(sync_list[p]);
			random_streams(bytes_sent + RANDOM_BYTES / 4);
		end
		settle();

		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
